FILE: rtl/pcf_pkg.sv
// Shared types and constants for the phase current filter with offset calibration.
// Used by pcf_ctrl, pcf_dp and the top level; depends on nothing else.
package pcf_pkg;

  typedef enum logic [1:0] {
    OP_SAMPLE     = 2'd0,
    OP_ZERO_BEGIN = 2'd1,
    OP_ZERO_APPLY = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    REG_CURRENT_COEFF = 1'b0,
    REG_ZERO_COEFF    = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic emit;
  } pcf_cmd_t;

  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int COEF_W     = 16;
  localparam int FILT_W     = 32;
  localparam int MA_AB_W    = 17;
  localparam int MA_C_W     = 18;
  localparam int MV_W       = 16;
  localparam int BUS_K_W    = 20;

  localparam logic [COEF_W-1:0] CURRENT_COEFF_RST = 16'd58982;
  localparam logic [COEF_W-1:0] ZERO_COEFF_RST    = 16'd64881;
  localparam logic [COEF_W:0]   COEF_ONE          = 17'h10000;
  localparam logic [BUS_K_W-1:0] BUS_MV_Q16       = 20'd834206;

  localparam int TRIM_A      = 1;
  localparam int TRIM_B      = 4;
  localparam int MA_LIMIT_AB = 36900;
  localparam int MA_LIMIT_C  = 73800;

endpackage

FILE: rtl/pcf_ctrl.sv
// Sequencer for the phase current filter: capture, state update and result load.
// Drives the input stall and output valid; depends on pcf_pkg.
module pcf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pcf_pkg::pcf_cmd_t cmd_o
);
  import pcf_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pcf_dp.sv
// Datapath of the phase current filter: coefficients, IIR filters, offset trackers
// and output scaling. Steered by pcf_ctrl commands; depends on pcf_pkg.
module pcf_dp #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcf_pkg::pcf_cmd_t           cmd_i,
  input  logic                        cfg_we_i,
  input  logic [pcf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcf_pkg::COEF_W-1:0]  cfg_wdata_i,
  input  logic [pcf_pkg::OP_W-1:0]    op_i,
  input  logic [ADC_BITS-1:0]         phase_a_raw_i,
  input  logic [ADC_BITS-1:0]         phase_b_raw_i,
  input  logic [ADC_BITS-1:0]         bus_raw_i,
  output logic signed [pcf_pkg::MA_AB_W-1:0] phase_a_ma_o,
  output logic signed [pcf_pkg::MA_AB_W-1:0] phase_b_ma_o,
  output logic signed [pcf_pkg::MA_C_W-1:0]  phase_c_ma_o,
  output logic [pcf_pkg::MV_W-1:0]    bus_mv_o,
  output logic                        zeroing_o
);
  import pcf_pkg::*;

  localparam int OFF_W  = ADC_BITS + 1;
  localparam int D_W    = ADC_BITS + 2;
  localparam int PF_W   = FILT_W + COEF_W + 1;
  localparam int PD_W   = D_W + COEF_W + 2;
  localparam int ACC_W  = ((PF_W > PD_W + FRAC_BITS) ? PF_W : PD_W + FRAC_BITS) + 2;
  localparam int SH_W   = ACC_W - COEF_W;
  localparam int TP_W   = ADC_BITS + COEF_W;
  localparam int RP_W   = ADC_BITS + COEF_W + 1;
  localparam int TS_W   = ADC_BITS + COEF_W + 2;
  localparam int BP_W   = ADC_BITS + BUS_K_W;
  localparam int BS_W   = (BP_W + 1 > COEF_W + MV_W + 1) ? BP_W + 1 : COEF_W + MV_W + 1;
  localparam int MA_W   = FILT_W + 6;

  localparam logic signed [ACC_W-1:0] ACC_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_W - 1);
  localparam logic signed [MA_W-1:0] MA_HALF =
    {{(MA_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [MA_W-1:0] LIM_AB = MA_W'(MA_LIMIT_AB);
  localparam logic signed [MA_W-1:0] LIM_C  = MA_W'(MA_LIMIT_C);
  localparam logic [BS_W-1:0] BUS_HALF = {{(BS_W-1){1'b0}}, 1'b1} << (COEF_W - 1);
  localparam logic [BS_W-COEF_W-1:0] MV_MAX =
    {{(BS_W-COEF_W-MV_W){1'b0}}, {(MV_W){1'b1}}};

  function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [SH_W-1:0] v);
    logic [SH_W-FILT_W:0] hi;
    hi = v[SH_W-1:FILT_W-1];
    if ((&hi) || !(|hi)) begin
      return v[FILT_W-1:0];
    end else if (v[SH_W-1]) begin
      return {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FILT_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [MA_W-1:0] ma_scale(input logic signed [MA_W-1:0] x,
                                                      input logic signed [MA_W-1:0] lim);
    logic signed [MA_W-1:0] v;
    v = ((x <<< 3) + x + MA_HALF) >>> FRAC_BITS;
    if (v > lim) begin
      return lim;
    end else if (v < -lim) begin
      return -lim;
    end else begin
      return v;
    end
  endfunction

  logic [COEF_W-1:0] cur_coeff_q, zero_coeff_q;
  logic signed [FILT_W-1:0] filt_a_q, filt_b_q;
  logic [OFF_W-1:0] offset_a_q, offset_b_q;
  logic [ADC_BITS-1:0] track_a_q, track_b_q;
  logic tracking_q;

  logic [OP_W-1:0] op_q;
  logic signed [PF_W-1:0] prod_fa_q, prod_fb_q;
  logic signed [PD_W-1:0] prod_da_q, prod_db_q;
  logic [TP_W-1:0] prod_ta_q, prod_tb_q;
  logic [RP_W-1:0] prod_ra_q, prod_rb_q;
  logic [BP_W-1:0] bus_prod_q;

  logic signed [MA_AB_W-1:0] phase_a_ma_q, phase_b_ma_q;
  logic signed [MA_C_W-1:0] phase_c_ma_q;
  logic [MV_W-1:0] bus_mv_q;
  logic zeroing_q;

  logic [COEF_W:0] cur_k1, zero_k1;
  logic signed [D_W-1:0] d_a, d_b;
  logic signed [ACC_W-1:0] acc_a, acc_b;
  logic signed [SH_W-1:0] sh_a, sh_b;
  logic [TS_W-1:0] trk_a, trk_b;
  logic signed [MA_W-1:0] ma_a, ma_b, ma_c, sum_c;
  logic [BS_W-1:0] bus_sum;
  logic [BS_W-COEF_W-1:0] bus_hi;
  logic [MV_W-1:0] mv;

  always_comb begin
    cur_k1  = COEF_ONE - {1'b0, cur_coeff_q};
    zero_k1 = COEF_ONE - {1'b0, zero_coeff_q};
    d_a = $signed({2'b00, phase_a_raw_i}) - $signed({1'b0, offset_a_q});
    d_b = $signed({2'b00, phase_b_raw_i}) - $signed({1'b0, offset_b_q});

    acc_a = ACC_W'(prod_fa_q) + (ACC_W'(prod_da_q) <<< FRAC_BITS) + ACC_HALF;
    acc_b = ACC_W'(prod_fb_q) + (ACC_W'(prod_db_q) <<< FRAC_BITS) + ACC_HALF;
    sh_a  = acc_a[ACC_W-1:COEF_W];
    sh_b  = acc_b[ACC_W-1:COEF_W];
    trk_a = TS_W'(prod_ta_q) + TS_W'(prod_ra_q);
    trk_b = TS_W'(prod_tb_q) + TS_W'(prod_rb_q);

    ma_a  = ma_scale(MA_W'(filt_a_q), LIM_AB);
    ma_b  = ma_scale(MA_W'(filt_b_q), LIM_AB);
    sum_c = -(MA_W'(filt_a_q) + MA_W'(filt_b_q));
    ma_c  = ma_scale(sum_c, LIM_C);

    bus_sum = BS_W'(bus_prod_q) + BUS_HALF;
    bus_hi  = bus_sum[BS_W-1:COEF_W];
    mv      = (bus_hi > MV_MAX) ? {(MV_W){1'b1}} : bus_hi[MV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_coeff_q  <= CURRENT_COEFF_RST;
      zero_coeff_q <= ZERO_COEFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CURRENT_COEFF: cur_coeff_q  <= cfg_wdata_i;
        REG_ZERO_COEFF:    zero_coeff_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_i;
      prod_fa_q  <= PF_W'(filt_a_q) * PF_W'($signed({1'b0, cur_coeff_q}));
      prod_fb_q  <= PF_W'(filt_b_q) * PF_W'($signed({1'b0, cur_coeff_q}));
      prod_da_q  <= PD_W'(d_a) * PD_W'($signed({1'b0, cur_k1}));
      prod_db_q  <= PD_W'(d_b) * PD_W'($signed({1'b0, cur_k1}));
      prod_ta_q  <= TP_W'(track_a_q) * TP_W'(zero_coeff_q);
      prod_tb_q  <= TP_W'(track_b_q) * TP_W'(zero_coeff_q);
      prod_ra_q  <= RP_W'(phase_a_raw_i) * RP_W'(zero_k1);
      prod_rb_q  <= RP_W'(phase_b_raw_i) * RP_W'(zero_k1);
      bus_prod_q <= BP_W'(bus_raw_i) * BP_W'(BUS_MV_Q16);
    end
    if (cmd_i.emit) begin
      phase_a_ma_q <= ma_a[MA_AB_W-1:0];
      phase_b_ma_q <= ma_b[MA_AB_W-1:0];
      phase_c_ma_q <= ma_c[MA_C_W-1:0];
      bus_mv_q     <= mv;
      zeroing_q    <= tracking_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_a_q   <= '0;
      filt_b_q   <= '0;
      offset_a_q <= '0;
      offset_b_q <= '0;
      track_a_q  <= '0;
      track_b_q  <= '0;
      tracking_q <= 1'b0;
    end else if (cmd_i.update) begin
      case (op_q)
        OP_SAMPLE: begin
          filt_a_q <= sat_filt(sh_a);
          filt_b_q <= sat_filt(sh_b);
          if (tracking_q) begin
            track_a_q <= trk_a[COEF_W +: ADC_BITS];
            track_b_q <= trk_b[COEF_W +: ADC_BITS];
          end
        end
        OP_ZERO_BEGIN: begin
          offset_a_q <= '0;
          offset_b_q <= '0;
          track_a_q  <= {1'b1, {(ADC_BITS-1){1'b0}}};
          track_b_q  <= {1'b1, {(ADC_BITS-1){1'b0}}};
          tracking_q <= 1'b1;
        end
        OP_ZERO_APPLY: begin
          offset_a_q <= {1'b0, track_a_q} + OFF_W'(TRIM_A);
          offset_b_q <= {1'b0, track_b_q} + OFF_W'(TRIM_B);
          tracking_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign phase_a_ma_o = phase_a_ma_q;
  assign phase_b_ma_o = phase_b_ma_q;
  assign phase_c_ma_o = phase_c_ma_q;
  assign bus_mv_o     = bus_mv_q;
  assign zeroing_o    = zeroing_q;

endmodule

FILE: rtl/phase_current_filter_with_offset_cal.sv
// Channel   Handshake                  Payload
// cfg       cfg_we_i                   cfg_idx_i, cfg_wdata_i
// in        in_valid_i / in_stall_o    op_i, phase_a_raw_i, phase_b_raw_i, bus_raw_i
// out       out_valid_o / out_stall_i  phase_a_ma_o, phase_b_ma_o, phase_c_ma_o,
//                                      bus_mv_o, zeroing_o
//
// A request passes through products, state update, then scaling into the
// output register; a new request is accepted only once the last one is loaded.
// This is set by the single-request sequencer in pcf_ctrl.
// Reset clears filters, offsets, trackers and restores both coefficients.
// While the output is stalled, a finished request waits in the scaling step.
// Top level of the phase current filter; instantiates pcf_ctrl and pcf_dp.
module phase_current_filter_with_offset_cal #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pcf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcf_pkg::COEF_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcf_pkg::OP_W-1:0]      op_i,
  input  logic [ADC_BITS-1:0]           phase_a_raw_i,
  input  logic [ADC_BITS-1:0]           phase_b_raw_i,
  input  logic [ADC_BITS-1:0]           bus_raw_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [pcf_pkg::MA_AB_W-1:0] phase_a_ma_o,
  output logic signed [pcf_pkg::MA_AB_W-1:0] phase_b_ma_o,
  output logic signed [pcf_pkg::MA_C_W-1:0]  phase_c_ma_o,
  output logic [pcf_pkg::MV_W-1:0]      bus_mv_o,
  output logic                          zeroing_o
);
  import pcf_pkg::*;

  pcf_cmd_t cmd;

  pcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pcf_dp #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .phase_a_raw_i (phase_a_raw_i),
    .phase_b_raw_i (phase_b_raw_i),
    .bus_raw_i     (bus_raw_i),
    .phase_a_ma_o  (phase_a_ma_o),
    .phase_b_ma_o  (phase_b_ma_o),
    .phase_c_ma_o  (phase_c_ma_o),
    .bus_mv_o      (bus_mv_o),
    .zeroing_o     (zeroing_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.update, cmd.emit}))
    else $error("more than one sequencer command at once");

  a_capture_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.update)
    else $error("captured request was not followed by a state update");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over a stalled result");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.emit))
    else $error("output valid rose without a result load");

endmodule
